// ===== design/dpr_pkg.sv =====
// Shared types and depth codes for the bitmap pixel to RGBA converter.
package dpr_pkg;

	localparam logic [5:0] DEPTH_1  = 6'd1;
	localparam logic [5:0] DEPTH_4  = 6'd4;
	localparam logic [5:0] DEPTH_8  = 6'd8;
	localparam logic [5:0] DEPTH_24 = 6'd24;
	localparam logic [5:0] DEPTH_32 = 6'd32;

	localparam logic [7:0] ALPHA_OPAQUE = 8'd255;
	localparam logic [7:0] ALPHA_CLEAR  = 8'd0;
	localparam logic [7:0] NIBBLE_MASK  = 8'h0f;
	localparam logic [2:0] BIT_TOP      = 3'd7;

	localparam logic KIND_PALETTE = 1'b0;
	localparam logic KIND_PIXEL   = 1'b1;

	typedef enum logic [1:0] {
		MODE_BGRA,
		MODE_BGR,
		MODE_PAL,
		MODE_BLACK
	} mode_t;

	typedef struct packed {
		logic        kind;
		logic [7:0]  palette_index;
		logic [23:0] palette_color;
		logic [31:0] pixel_word;
		logic [2:0]  column_low;
		logic        mask_bit;
	} pixel_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} rgba_t;

	typedef struct packed {
		mode_t      mode;
		logic [7:0] idx;
	} sel_t;

endpackage

// ===== design/dpr_palette_ram.sv =====
// Palette memory: one write port, one registered read port.
module dpr_palette_ram #(
	parameter int DEPTH = 256,
	parameter int AW    = 8
) (
	input  logic          clk,
	input  logic          we,
	input  logic [AW-1:0] waddr,
	input  logic [23:0]   wdata,
	input  logic          re,
	input  logic [AW-1:0] raddr,
	output logic [23:0]   rdata
);

	logic [23:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// hold read data unless a new read is issued
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ===== design/dpr_index_sel.sv =====
// Depth decode and palette index extraction from the low pixel byte.
module dpr_index_sel (
	input  logic [5:0]  depth,
	input  logic [7:0]  byte0,
	input  logic [2:0]  column_low,
	output dpr_pkg::sel_t sel
);
	import dpr_pkg::*;

	always_comb begin
		sel.mode = MODE_BLACK;
		sel.idx  = '0;
		unique case (depth)
			DEPTH_32: begin
				sel.mode = MODE_BGRA;
			end
			DEPTH_24: begin
				sel.mode = MODE_BGR;
			end
			DEPTH_8: begin
				sel.mode = MODE_PAL;
				sel.idx  = byte0;
			end
			DEPTH_4: begin
				sel.mode = MODE_PAL;
				// even column takes the high nibble
				sel.idx  = column_low[0] ? (byte0 & NIBBLE_MASK) : ((byte0 >> 4) & NIBBLE_MASK);
			end
			DEPTH_1: begin
				sel.mode = MODE_PAL;
				sel.idx  = {7'd0, byte0[BIT_TOP - column_low]};
			end
			default: begin
				sel.mode = MODE_BLACK;
			end
		endcase
	end

endmodule

// ===== design/dib_pixel_to_rgba.sv =====
// Top level: bitmap cursor pixel to RGBA converter with palette store.
//
// Input words arrive on pixel / pixel_valid / pixel_ready. A word of kind
// palette writes one palette entry and yields no result; a word of kind
// pixel yields exactly one RGBA word on rgba / rgba_valid / rgba_ready.
// The user must write the source depth register (depth_we / depth_wdata)
// only while the block is idle; the block does not enforce this. The
// register resets to 32 (BGRA pass-through).
// The edge that accepts a pixel word captures the decoded depth, the
// palette index check and the palette read into stage 1; stage 1 then
// forms the channels into the output register once that can advance,
// raising rgba_valid. One word is accepted every clock while the output
// is drained: one pixel per cycle.
//
// Reset clears the pipeline valid flags and sets the depth register to 32;
// palette contents are undefined until written. When the receiver stalls,
// the output register holds, the first stage holds with its read data, and
// pixel_ready drops while both stages are full and rgba_ready is low.
module dib_pixel_to_rgba #(
	parameter int PALETTE_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           depth_we,
	input  logic [5:0]     depth_wdata,
	input  logic           pixel_valid,
	output logic           pixel_ready,
	input  dpr_pkg::pixel_t pixel,
	output logic           rgba_valid,
	input  logic           rgba_ready,
	output dpr_pkg::rgba_t  rgba
);
	import dpr_pkg::*;

	localparam int AW = (PALETTE_DEPTH > 1) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [8:0] DEPTH_LIM = 9'(PALETTE_DEPTH);

	logic [5:0]  depth_q;
	sel_t        sel;
	logic        accept;
	logic        accept_pix;
	logic        pal_we;
	logic        idx_over;
	logic        s1_adv;
	logic        s2_adv;
	logic [23:0] rd_s1;

	logic        s1_valid;
	mode_t       mode_s1;
	logic        over_s1;
	logic        clear_s1;
	logic [31:0] word_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= DEPTH_32;
		end else if (depth_we) begin
			depth_q <= depth_wdata;
		end
	end

	dpr_index_sel u_sel (
		.depth      (depth_q),
		.byte0      (pixel.pixel_word[7:0]),
		.column_low (pixel.column_low),
		.sel        (sel)
	);

	assign s2_adv      = !rgba_valid || rgba_ready;
	assign s1_adv      = s1_valid && s2_adv;
	assign pixel_ready = !s1_valid || s2_adv;
	assign accept      = pixel_valid && pixel_ready;
	assign accept_pix  = accept && (pixel.kind == KIND_PIXEL);
	assign pal_we      = accept && (pixel.kind == KIND_PALETTE)
		&& ({1'b0, pixel.palette_index} < DEPTH_LIM);
	assign idx_over    = {1'b0, sel.idx} >= DEPTH_LIM;

	dpr_palette_ram #(
		.DEPTH (PALETTE_DEPTH),
		.AW    (AW)
	) u_ram (
		.clk   (clk),
		.we    (pal_we),
		.waddr (pixel.palette_index[AW-1:0]),
		.wdata (pixel.palette_color),
		.re    (accept_pix),
		.raddr (sel.idx[AW-1:0]),
		.rdata (rd_s1)
	);

	// stage 1: decoded mode and pixel bytes beside the palette read
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid <= 1'b0;
		end else if (pixel_ready) begin
			s1_valid <= accept_pix;
		end
	end

	always_ff @(posedge clk) begin
		if (accept_pix) begin
			mode_s1  <= sel.mode;
			over_s1  <= idx_over;
			clear_s1 <= (depth_q != DEPTH_32) && pixel.mask_bit;
			word_s1  <= pixel.pixel_word;
		end
	end

	// stage 2: output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgba_valid <= 1'b0;
		end else if (s2_adv) begin
			rgba_valid <= s1_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_adv) begin
			case (mode_s1)
				MODE_BGRA: begin
					rgba.blue  <= word_s1[7:0];
					rgba.green <= word_s1[15:8];
					rgba.red   <= word_s1[23:16];
				end
				MODE_BGR: begin
					rgba.blue  <= word_s1[7:0];
					rgba.green <= word_s1[15:8];
					rgba.red   <= word_s1[23:16];
				end
				MODE_PAL: begin
					rgba.blue  <= over_s1 ? 8'd0 : rd_s1[7:0];
					rgba.green <= over_s1 ? 8'd0 : rd_s1[15:8];
					rgba.red   <= over_s1 ? 8'd0 : rd_s1[23:16];
				end
				default: begin
					rgba.blue  <= 8'd0;
					rgba.green <= 8'd0;
					rgba.red   <= 8'd0;
				end
			endcase
			if (mode_s1 == MODE_BGRA) begin
				rgba.alpha <= word_s1[31:24];
			end else begin
				rgba.alpha <= clear_s1 ? ALPHA_CLEAR : ALPHA_OPAQUE;
			end
		end
	end

	a_pal_no_result: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && pixel.kind == KIND_PALETTE) |=> (s1_valid == $past(s1_valid && !s1_adv)))
		else $error("palette word entered the pixel pipeline");

	a_pix_enters: assert property (@(posedge clk) disable iff (!arst_n)
		accept_pix |=> s1_valid)
		else $error("accepted pixel word lost before stage 1");

	a_s1_to_out: assert property (@(posedge clk) disable iff (!arst_n)
		s1_adv |=> rgba_valid)
		else $error("stage 1 advanced without output valid");

	a_bgra_alpha: assert property (@(posedge clk) disable iff (!arst_n)
		(s1_adv && mode_s1 == MODE_BGRA) |=> (rgba.alpha == $past(word_s1[31:24])))
		else $error("BGRA alpha not passed through");

endmodule
